@@ rtl/bitmap_text_renderer_clipped_defines.svh @@
// Assertion macros of the character generator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef BITMAP_TEXT_RENDERER_CLIPPED_DEFINES_SVH
`define BITMAP_TEXT_RENDERER_CLIPPED_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BTR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BTR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/btr_pkg.sv @@
// Shared constants, types and helpers of the 8x16 character generator.
// No dependencies; the other RTL files that use it refer to it by scoped names.
package btr_pkg;

    localparam int GlyphCount = 95;
    localparam int GlyphRows  = 16;
    localparam int GlyphCols  = 8;
    localparam int FontDepth  = GlyphCount * GlyphRows;
    localparam int FontAw     = $clog2(FontDepth);
    localparam int CoordW     = 13;
    localparam int CfgIdxW    = 4;
    localparam int CfgDataW   = 32;

    localparam logic [CfgIdxW-1:0] CfgOriginX    = 4'd0;
    localparam logic [CfgIdxW-1:0] CfgOriginY    = 4'd1;
    localparam logic [CfgIdxW-1:0] CfgClipLeft   = 4'd2;
    localparam logic [CfgIdxW-1:0] CfgClipTop    = 4'd3;
    localparam logic [CfgIdxW-1:0] CfgClipWidth  = 4'd4;
    localparam logic [CfgIdxW-1:0] CfgClipHeight = 4'd5;
    localparam logic [CfgIdxW-1:0] CfgDrawColor  = 4'd6;
    localparam logic [CfgIdxW-1:0] CfgWrapEnable = 4'd7;

    localparam logic ReqChar = 1'b0;
    localparam logic ReqFont = 1'b1;

    localparam logic [7:0] CharNewline  = 8'h0A;
    localparam logic [7:0] CharSpace    = 8'h20;
    localparam logic [7:0] CharQuestion = 8'h3F;
    localparam logic [7:0] CharTilde    = 8'h7E;

    typedef struct packed {
        logic [11:0]       origin_x;
        logic [11:0]       origin_y;
        logic [11:0]       clip_left;
        logic [11:0]       clip_top;
        logic [CoordW-1:0] clip_right;
        logic [CoordW-1:0] clip_bottom;
        logic [31:0]       draw_color;
        logic              wrap_enable;
    } t_cfg;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [6:0]        glyph;
    } t_job;

    typedef struct packed {
        logic slot_free;
        logic font_free;
    } t_rg_status;

    // y + step, saturated at the largest coordinate.
    function automatic logic [CoordW-1:0] coord_add_sat(logic [CoordW-1:0] y, logic [5:0] step);
        logic [CoordW:0] s;
        s = {1'b0, y} + (CoordW + 1)'(step);
        return s[CoordW] ? {CoordW{1'b1}} : s[CoordW-1:0];
    endfunction

endpackage

@@ rtl/btr_ifs.sv @@
// Valid/ready channel interfaces of the character generator.
// Depends on nothing.
interface btr_char_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] char_code;
    logic       first_of_string;
    logic [6:0] glyph_index;
    logic [3:0] glyph_row;
    logic [7:0] row_bits;

    modport source (output valid, req_type, char_code, first_of_string, glyph_index,
                    glyph_row, row_bits, input ready);
    modport sink (input valid, req_type, char_code, first_of_string, glyph_index,
                  glyph_row, row_bits, output ready);
endinterface

interface btr_row_if;
    logic        valid;
    logic        ready;
    logic [12:0] row_x;
    logic [12:0] row_y;
    logic [7:0]  pixel_mask;
    logic [31:0] pixel_color;
    logic        last_row;

    modport source (output valid, row_x, row_y, pixel_mask, pixel_color, last_row,
                    input ready);
    modport sink (input valid, row_x, row_y, pixel_mask, pixel_color, last_row,
                  output ready);
endinterface

interface btr_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cfg_index;
    logic [31:0] cfg_data;

    modport source (output valid, cfg_index, cfg_data, input ready);
    modport sink (input valid, cfg_index, cfg_data, output ready);
endinterface

@@ rtl/btr_ram.sv @@
// Generic single-write, single-read RAM with registered, enabled read.
// No dependencies.
module btr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1520
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/btr_cfg_regs.sv @@
// Configuration register bank with precomputed clip right and bottom edges.
// Depends on btr_pkg and btr_ifs.
module btr_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    btr_cfg_if.sink         i_cfg,
    output btr_pkg::t_cfg   o_cfg
);

    logic [11:0] r_clip_width,  n_clip_width;
    logic [11:0] r_clip_height, n_clip_height;
    btr_pkg::t_cfg r_cfg, n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg         = r_cfg;
        n_clip_width  = r_clip_width;
        n_clip_height = r_clip_height;
        if (i_cfg.valid) begin
            case (i_cfg.cfg_index)
                btr_pkg::CfgOriginX:    n_cfg.origin_x    = i_cfg.cfg_data[11:0];
                btr_pkg::CfgOriginY:    n_cfg.origin_y    = i_cfg.cfg_data[11:0];
                btr_pkg::CfgClipLeft:   n_cfg.clip_left   = i_cfg.cfg_data[11:0];
                btr_pkg::CfgClipTop:    n_cfg.clip_top    = i_cfg.cfg_data[11:0];
                btr_pkg::CfgClipWidth:  n_clip_width      = i_cfg.cfg_data[11:0];
                btr_pkg::CfgClipHeight: n_clip_height     = i_cfg.cfg_data[11:0];
                btr_pkg::CfgDrawColor:  n_cfg.draw_color  = i_cfg.cfg_data;
                btr_pkg::CfgWrapEnable: n_cfg.wrap_enable = i_cfg.cfg_data[0];
                default: ;
            endcase
        end
        // keep the edges in step with the fields they follow from
        n_cfg.clip_right  = {1'b0, n_cfg.clip_left} + {1'b0, n_clip_width};
        n_cfg.clip_bottom = {1'b0, n_cfg.clip_top} + {1'b0, n_clip_height};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x    <= '0;
            r_cfg.origin_y    <= '0;
            r_cfg.clip_left   <= '0;
            r_cfg.clip_top    <= '0;
            r_cfg.clip_right  <= 13'd4095;
            r_cfg.clip_bottom <= 13'd4095;
            r_cfg.draw_color  <= 32'hFFFF_FFFF;
            r_cfg.wrap_enable <= 1'b0;
            r_clip_width      <= 12'd4095;
            r_clip_height     <= 12'd4095;
        end else begin
            r_cfg         <= n_cfg;
            r_clip_width  <= n_clip_width;
            r_clip_height <= n_clip_height;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/btr_cursor.sv @@
// Text cursor: origin reset, newline, wrap and stop logic; issues glyph jobs.
// Depends on btr_pkg.
module btr_cursor #(
    parameter int SCREEN_COLUMNS = 480
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [7:0]                  i_code,
    input  logic                        i_first,
    input  btr_pkg::t_cfg               i_cfg,
    output logic                        o_load,
    output btr_pkg::t_job               o_job
);

    localparam logic [btr_pkg::CoordW-1:0] ScreenCols = btr_pkg::CoordW'(SCREEN_COLUMNS);

    logic [btr_pkg::CoordW-1:0] r_cx, n_cx;
    logic [btr_pkg::CoordW-1:0] r_cy, n_cy;
    logic                       r_stop, n_stop;
    logic [btr_pkg::CoordW-1:0] cx0, cy0, cx_step, ox, cy_a, cy_b;
    logic                       stop0, wrap1, wrap2, printable;
    logic [7:0]                 code_sel;

    always_comb begin
        ox        = {1'b0, i_cfg.origin_x};
        cx0       = i_first ? ox : r_cx;
        cy0       = i_first ? {1'b0, i_cfg.origin_y} : r_cy;
        stop0     = i_first ? 1'b0 : r_stop;
        printable = i_code inside {[btr_pkg::CharSpace:btr_pkg::CharTilde]};
        code_sel  = printable ? i_code : btr_pkg::CharQuestion;
        cx_step   = cx0 + btr_pkg::CoordW'(btr_pkg::GlyphCols);
        wrap1     = cx_step > ScreenCols;
        wrap2     = i_cfg.wrap_enable &&
                    (wrap1 ? (ox >= i_cfg.clip_right) : (cx_step >= i_cfg.clip_right));
        cy_a      = btr_pkg::coord_add_sat(cy0, 6'(btr_pkg::GlyphRows));
        cy_b      = btr_pkg::coord_add_sat(cy0, 6'(2 * btr_pkg::GlyphRows));

        o_load    = 1'b0;
        o_job.x   = cx0;
        o_job.y   = cy0;
        o_job.glyph = 7'(code_sel - btr_pkg::CharSpace);

        n_cx   = r_cx;
        n_cy   = r_cy;
        n_stop = r_stop;
        if (i_accept) begin
            n_cx   = cx0;
            n_cy   = cy0;
            n_stop = stop0;
            if (!stop0) begin
                if (i_code == btr_pkg::CharNewline) begin
                    n_cx = ox;
                    n_cy = cy_a;
                end else begin
                    o_load = 1'b1;
                    n_cx   = (wrap1 || wrap2) ? ox : cx_step;
                    n_cy   = (wrap1 && wrap2) ? cy_b : ((wrap1 || wrap2) ? cy_a : cy0);
                    n_stop = n_cy > i_cfg.clip_bottom;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_stop <= 1'b0;
        end else begin
            r_cx   <= n_cx;
            r_cy   <= n_cy;
            r_stop <= n_stop;
        end
    end

endmodule

@@ rtl/btr_row_gen.sv @@
// Glyph row sequencer: font read, clip mask, and the result register.
// Depends on btr_pkg, btr_ifs and the assertion macro header.
`include "bitmap_text_renderer_clipped_defines.svh"

module btr_row_gen (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  btr_pkg::t_job                i_job,
    input  btr_pkg::t_cfg                i_cfg,
    input  logic                         i_font_we,
    output logic                         o_re,
    output logic [btr_pkg::FontAw-1:0]   o_raddr,
    input  logic [7:0]                   i_rdata,
    output btr_pkg::t_rg_status          o_status,
    btr_row_if.source                    o_row
);

    // job slot: character being read out row by row
    logic                       r_job_valid;
    btr_pkg::t_job              r_job;
    logic [3:0]                 r_row;
    // read stage: font data arrives from the RAM with these
    logic                       r_b_valid;
    logic [btr_pkg::CoordW-1:0] r_b_x, r_b_y;
    logic [7:0]                 r_b_mask;
    logic                       r_b_last;
    // result register
    logic                       r_out_valid;
    logic [btr_pkg::CoordW-1:0] r_out_x, r_out_y;
    logic [7:0]                 r_out_mask;
    logic [31:0]                r_out_color;
    logic                       r_out_last;

    logic                       w_out_adv, w_b_free, w_issue, w_last_issue, y_in;
    logic [btr_pkg::CoordW:0]   y_true, px;
    logic [7:0]                 n_b_mask;

    assign w_out_adv    = !r_out_valid || o_row.ready;
    assign w_b_free     = !r_b_valid || w_out_adv;
    assign w_issue      = r_job_valid && w_b_free;
    assign w_last_issue = w_issue && (r_row == 4'(btr_pkg::GlyphRows - 1));

    assign o_re    = w_issue;
    assign o_raddr = btr_pkg::FontAw'({r_job.glyph, r_row});

    assign o_status.slot_free = !r_job_valid || w_last_issue;
    assign o_status.font_free = !r_job_valid;

    // clip test for the row being issued; the font bits are ANDed in later
    always_comb begin
        px     = '0;
        y_true = {1'b0, r_job.y} + (btr_pkg::CoordW + 1)'(r_row);
        y_in   = (y_true >= {2'b0, i_cfg.clip_top}) && (y_true < {1'b0, i_cfg.clip_bottom});
        for (int b = 0; b < btr_pkg::GlyphCols; b++) begin
            px = {1'b0, r_job.x} + (btr_pkg::CoordW + 1)'(btr_pkg::GlyphCols - 1 - b);
            n_b_mask[b] = y_in && (px >= {2'b0, i_cfg.clip_left}) &&
                          (px < {1'b0, i_cfg.clip_right});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_row       <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_job_valid <= 1'b1;
                r_row       <= '0;
            end else if (w_last_issue) begin
                r_job_valid <= 1'b0;
            end
            if (w_issue && !i_load) begin
                r_row <= r_row + 4'd1;
            end
            if (w_b_free) begin
                r_b_valid <= w_issue;
            end
            if (w_out_adv) begin
                r_out_valid <= r_b_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_job <= i_job;
        end
        if (w_issue) begin
            r_b_x    <= r_job.x;
            r_b_y    <= btr_pkg::coord_add_sat(r_job.y, 6'(r_row));
            r_b_mask <= n_b_mask;
            r_b_last <= (r_row == 4'(btr_pkg::GlyphRows - 1));
        end
        if (w_out_adv && r_b_valid) begin
            r_out_x     <= r_b_x;
            r_out_y     <= r_b_y;
            r_out_mask  <= i_rdata & r_b_mask;
            r_out_color <= i_cfg.draw_color;
            r_out_last  <= r_b_last;
        end
    end

    assign o_row.valid       = r_out_valid;
    assign o_row.row_x       = r_out_x;
    assign o_row.row_y       = r_out_y;
    assign o_row.pixel_mask  = r_out_mask;
    assign o_row.pixel_color = r_out_color;
    assign o_row.last_row    = r_out_last;

    `BTR_ASSERT_SAME(a_load_slot_free, i_clk, i_rst_n, i_load,
        !r_job_valid || w_last_issue, "glyph job loaded over a busy slot")
    `BTR_ASSERT_SAME(a_font_write_idle, i_clk, i_rst_n, i_font_we,
        !r_job_valid, "font written while glyph rows still being read")
    `BTR_ASSERT_NEXT(a_row_restart, i_clk, i_rst_n, w_last_issue,
        r_row == 4'd0, "row counter not back at the top after the last row")
    `BTR_ASSERT_NEXT(a_read_held, i_clk, i_rst_n, r_b_valid && !w_out_adv,
        r_b_valid && $stable(i_rdata), "font data lost while the result stalled")

endmodule

@@ rtl/bitmap_text_renderer_clipped.sv @@
// Top level of the clipped 8x16 character generator.
// Depends on btr_pkg, btr_ifs, btr_ram, btr_cfg_regs, btr_cursor and btr_row_gen.
//
//  port    | dir | transaction carries
//  --------+-----+-----------------------------------------------------------
//  i_char  | in  | one character, or one font row write
//  o_row   | out | one clipped glyph row: position, mask, colour, last flag
//  i_cfg   | in  | one configuration register write (index, data)
//
// Cycles: a printed character gives 16 row transactions, one per cycle while
//   o_row is ready; the single font RAM read port, read once per glyph row,
//   limits how fast characters go in.
// Newlines, characters of a stopped string and font writes give no row transactions.
// Path: an accepted character passes the job slot, the read stage and the
//   result register before its first row is offered on o_row.
// Reset: synchronous, active low; clears the cursor, control state and
//   configuration. The font RAM holds nothing until written and needs no sweep.
// Stalls: the result register holds while o_row is stalled; the next character
//   is taken as the current one issues its last font read.
module bitmap_text_renderer_clipped #(
    parameter int SCREEN_COLUMNS = 480
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    btr_char_if.sink   i_char,
    btr_row_if.source  o_row,
    btr_cfg_if.sink    i_cfg
);

    btr_pkg::t_cfg        cfg;
    btr_pkg::t_job        job;
    btr_pkg::t_rg_status  rg_status;
    logic                 char_accept, font_we, job_load, ram_re;
    logic [btr_pkg::FontAw-1:0] ram_raddr;
    logic [7:0]           ram_rdata;

    // Font writes wait for the glyph reads in flight; characters only need the job slot.
    assign i_char.ready = (i_char.req_type == btr_pkg::ReqFont) ? rg_status.font_free
                                                                  : rg_status.slot_free;

    assign char_accept = i_char.valid && i_char.ready && (i_char.req_type == btr_pkg::ReqChar);
    // Drop writes to glyph numbers beyond the font.
    assign font_we     = i_char.valid && i_char.ready && (i_char.req_type == btr_pkg::ReqFont) &&
                         (i_char.glyph_index < 7'(btr_pkg::GlyphCount));

    btr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    btr_cursor #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS)
    ) u_cursor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (char_accept),
        .i_code   (i_char.char_code),
        .i_first  (i_char.first_of_string),
        .i_cfg    (cfg),
        .o_load   (job_load),
        .o_job    (job)
    );

    // Font store: glyph number in the upper address bits, glyph row in the lower.
    btr_ram #(
        .WIDTH (8),
        .DEPTH (btr_pkg::FontDepth)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (font_we),
        .i_waddr (btr_pkg::FontAw'({i_char.glyph_index, i_char.glyph_row})),
        .i_wdata (i_char.row_bits),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    btr_row_gen u_rows (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (job_load),
        .i_job     (job),
        .i_cfg     (cfg),
        .i_font_we (font_we),
        .o_re      (ram_re),
        .o_raddr   (ram_raddr),
        .i_rdata   (ram_rdata),
        .o_status  (rg_status),
        .o_row     (o_row)
    );

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for the clipped 8x16 character generator.
// Depends on btr_pkg, the btr_ifs channel interfaces and bitmap_text_renderer_clipped.
// Drives characters and font writes, predicts every glyph row and checks it.
module tb;

    localparam int          ScreenColumns = 480;
    localparam int unsigned CoordMax      = 8191;
    localparam int          SettleCycles  = 8;      // margin past the pipeline latency
    localparam int          HoldCycles    = 600;    // long receiver hold-off
    localparam int          CycleLimit    = 600000;
    localparam int          LoadedGlyphs  = 4;      // glyphs loaded in full before any drawing
    localparam logic [7:0]  CharA         = 8'h41;

    // One transaction on the character channel.
    typedef struct packed {
        logic       req_type;
        logic [7:0] char_code;
        logic       first_of_string;
        logic [6:0] glyph_index;
        logic [3:0] glyph_row;
        logic [7:0] row_bits;
    } t_text_req;

    // One transaction on the glyph row channel.
    typedef struct packed {
        logic [12:0] row_x;
        logic [12:0] row_y;
        logic [7:0]  pixel_mask;
        logic [31:0] pixel_color;
        logic        last_row;
    } t_glyph_row;

    logic i_clk;
    logic i_rst_n;

    btr_char_if char_bus ();
    btr_row_if  row_bus ();
    btr_cfg_if  cfg_bus ();

    bitmap_text_renderer_clipped #(
        .SCREEN_COLUMNS(ScreenColumns)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_char (char_bus),
        .o_row  (row_bus),
        .i_cfg  (cfg_bus)
    );

    // Requests waiting for the driver, and glyph rows the block still owes us.
    t_text_req  backlog[$];
    t_glyph_row rows_due[$];
    int         in_flight  = 0;   // queued requests not yet accepted
    int         mismatches = 0;
    bit         char_taken = 1'b0;

    // Pacing knobs, set per phase by the stimulus process.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Receiver hold-off: toggle hold_req to start a stretch of HoldCycles.
    bit hold_req  = 1'b0;
    bit hold_ack  = 1'b0;
    int hold_left = 0;

    int cycle_count = 0;

    // Shadow of the configuration registers.
    logic [11:0] org_x, org_y, clip_l, clip_t, clip_w, clip_h;
    logic [31:0] ink;
    logic        wrap_on;

    // Shadow of the cursor and the font.
    logic [12:0] cur_x, cur_y;
    logic        stopped;
    logic [7:0]  font_rows [btr_pkg::FontDepth];

    // ------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Abort a hung run; the limit is many times the slowest legal run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("** bitmap_text_renderer_clipped: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Row prediction
    // ------------------------------------------------------------------

    // Return to the line start and drop one glyph height, saturating at the bottom.
    function automatic void line_feed();
        int unsigned y;
        y = int'(cur_y) + btr_pkg::GlyphRows;
        cur_x = {1'b0, org_x};
        cur_y = (y > CoordMax) ? 13'(CoordMax) : 13'(y);
    endfunction

    // Apply one accepted request to the shadow state and queue the rows it draws.
    function automatic void render_request(input t_text_req r);
        int unsigned right, bottom, py, px;
        logic [7:0]  code, inside_bits;
        t_glyph_row  due;
        if (r.req_type == btr_pkg::ReqFont) begin
            // Out-of-range glyph numbers are dropped by the block
            if (r.glyph_index < btr_pkg::GlyphCount)
                font_rows[int'(r.glyph_index) * btr_pkg::GlyphRows + int'(r.glyph_row)] =
                    r.row_bits;
            return;
        end
        if (r.first_of_string) begin
            cur_x   = {1'b0, org_x};
            cur_y   = {1'b0, org_y};
            stopped = 1'b0;
        end
        if (stopped)
            return;
        if (r.char_code == btr_pkg::CharNewline) begin
            line_feed();
            return;
        end
        code = (r.char_code < btr_pkg::CharSpace || r.char_code > btr_pkg::CharTilde)
               ? btr_pkg::CharQuestion : r.char_code;
        right  = int'(clip_l) + int'(clip_w);
        bottom = int'(clip_t) + int'(clip_h);
        for (int i = 0; i < btr_pkg::GlyphRows; i++) begin
            // Clip against the true row, not the saturated one
            py = int'(cur_y) + i;
            inside_bits = '0;
            if (py >= clip_t && py < bottom) begin
                for (int b = 0; b < btr_pkg::GlyphCols; b++) begin
                    px = int'(cur_x) + btr_pkg::GlyphCols - 1 - b;
                    if (px >= clip_l && px < right)
                        inside_bits[b] = 1'b1;
                end
            end
            due.row_x       = cur_x;
            due.row_y       = (py > CoordMax) ? 13'(CoordMax) : 13'(py);
            due.pixel_mask  = font_rows[(int'(code) - int'(btr_pkg::CharSpace))
                                        * btr_pkg::GlyphRows + i] & inside_bits;
            due.pixel_color = ink;
            due.last_row    = (i == btr_pkg::GlyphRows - 1);
            rows_due.push_back(due);
        end
        cur_x = cur_x + 13'(btr_pkg::GlyphCols);
        if (int'(cur_x) > ScreenColumns)
            line_feed();
        if (wrap_on && int'(cur_x) >= right)
            line_feed();
        if (int'(cur_y) > bottom)
            stopped = 1'b1;
    endfunction

    function automatic void shadow_write(input logic [btr_pkg::CfgIdxW-1:0] idx,
                                         input logic [btr_pkg::CfgDataW-1:0] d);
        case (idx)
            btr_pkg::CfgOriginX:    org_x   = d[11:0];
            btr_pkg::CfgOriginY:    org_y   = d[11:0];
            btr_pkg::CfgClipLeft:   clip_l  = d[11:0];
            btr_pkg::CfgClipTop:    clip_t  = d[11:0];
            btr_pkg::CfgClipWidth:  clip_w  = d[11:0];
            btr_pkg::CfgClipHeight: clip_h  = d[11:0];
            btr_pkg::CfgDrawColor:  ink     = d;
            btr_pkg::CfgWrapEnable: wrap_on = d[0];
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Character channel driver: change inputs on the falling edge only
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_chars
        t_text_req nxt;
        if (!i_rst_n) begin
            char_bus.valid <= 1'b0;
        end else if (!char_bus.valid || char_taken) begin
            // Offer the next request unless this cycle is an idle one
            if (backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = backlog.pop_front();
                char_bus.req_type        <= nxt.req_type;
                char_bus.char_code       <= nxt.char_code;
                char_bus.first_of_string <= nxt.first_of_string;
                char_bus.glyph_index     <= nxt.glyph_index;
                char_bus.glyph_row       <= nxt.glyph_row;
                char_bus.row_bits        <= nxt.row_bits;
                char_bus.valid           <= 1'b1;
            end else begin
                char_bus.valid <= 1'b0;
            end
        end
    end

    // Row channel back-pressure: random stalls, forced low during a hold-off.
    always @(negedge i_clk) begin
        row_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    // Count down a hold-off stretch once the stimulus asks for one.
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_left <= HoldCycles;
            hold_ack  <= hold_req;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_glyph_row want;
        t_text_req  seen;
        if (i_rst_n && row_bus.valid && row_bus.ready) begin
            if (rows_due.size() == 0) begin
                $error("unexpected row: row_x=%0d row_y=%0d pixel_mask=%02h",
                       row_bus.row_x, row_bus.row_y, row_bus.pixel_mask);
                mismatches++;
            end else begin
                want = rows_due.pop_front();
                if (row_bus.row_x !== want.row_x) begin
                    $error("row_x: expected %0d, got %0d", want.row_x, row_bus.row_x);
                    mismatches++;
                end
                if (row_bus.row_y !== want.row_y) begin
                    $error("row_y: expected %0d, got %0d", want.row_y, row_bus.row_y);
                    mismatches++;
                end
                if (row_bus.pixel_mask !== want.pixel_mask) begin
                    $error("pixel_mask: expected %02h, got %02h",
                           want.pixel_mask, row_bus.pixel_mask);
                    mismatches++;
                end
                if (row_bus.pixel_color !== want.pixel_color) begin
                    $error("pixel_color: expected %08h, got %08h",
                           want.pixel_color, row_bus.pixel_color);
                    mismatches++;
                end
                if (row_bus.last_row !== want.last_row) begin
                    $error("last_row: expected %0b, got %0b", want.last_row, row_bus.last_row);
                    mismatches++;
                end
            end
        end
        // Predict on acceptance; the first row cannot be due in this same cycle
        char_taken = i_rst_n && char_bus.valid && char_bus.ready;
        if (char_taken) begin
            seen.req_type        = char_bus.req_type;
            seen.char_code       = char_bus.char_code;
            seen.first_of_string = char_bus.first_of_string;
            seen.glyph_index     = char_bus.glyph_index;
            seen.glyph_row       = char_bus.glyph_row;
            seen.row_bits        = char_bus.row_bits;
            render_request(seen);
            in_flight--;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Codes of the glyphs that are loaded in full before any drawing.
    function automatic logic [7:0] font_code(input int k);
        case (k)
            0:       return btr_pkg::CharSpace;
            1:       return btr_pkg::CharQuestion;
            2:       return CharA;
            default: return btr_pkg::CharTilde;
        endcase
    endfunction

    // A printable character whose glyph is fully loaded.
    function automatic logic [7:0] loaded_char();
        return font_code(int'($urandom_range(0, LoadedGlyphs - 1)));
    endfunction

    // Character request; the font-write fields carry random don't-care bits.
    function automatic t_text_req char_req(input logic [7:0] code, input logic first);
        t_text_req r;
        r.req_type        = btr_pkg::ReqChar;
        r.char_code       = code;
        r.first_of_string = first;
        r.glyph_index     = 7'($urandom);
        r.glyph_row       = 4'($urandom);
        r.row_bits        = 8'($urandom);
        return r;
    endfunction

    // Font row write; the character fields carry random don't-care bits.
    function automatic t_text_req font_req(input int idx, input int row, input int bits);
        t_text_req r;
        r.req_type        = btr_pkg::ReqFont;
        r.char_code       = 8'($urandom);
        r.first_of_string = 1'($urandom);
        r.glyph_index     = 7'(idx);
        r.glyph_row       = 4'(row);
        r.row_bits        = 8'(bits);
        return r;
    endfunction

    task automatic queue_req(input t_text_req r);
        backlog.push_back(r);
        in_flight++;
    endtask

    // Wait until every request is in and every row out, then let the pipe settle.
    task automatic drain();
        do @(negedge i_clk); while (in_flight != 0 || rows_due.size() != 0);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [btr_pkg::CfgIdxW-1:0] idx,
                             input logic [btr_pkg::CfgDataW-1:0] d);
        @(negedge i_clk);
        cfg_bus.cfg_index <= idx;
        cfg_bus.cfg_data  <= d;
        cfg_bus.valid     <= 1'b1;
        do @(posedge i_clk); while (!cfg_bus.ready);
        shadow_write(idx, d);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Write all eight registers; unused upper bits carry junk the block must drop.
    task automatic program_regs(input int ox, input int oy, input int cl, input int ct,
                                input int cw, input int ch, input logic [31:0] colour,
                                input bit wrap);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(btr_pkg::CfgOriginX,    {junk[31:12], 12'(ox)});
        write_reg(btr_pkg::CfgOriginY,    {junk[19:0],  12'(oy)});
        write_reg(btr_pkg::CfgClipLeft,   {junk[27:8],  12'(cl)});
        write_reg(btr_pkg::CfgClipTop,    {~junk[31:12], 12'(ct)});
        write_reg(btr_pkg::CfgClipWidth,  {~junk[19:0], 12'(cw)});
        write_reg(btr_pkg::CfgClipHeight, {~junk[27:8], 12'(ch)});
        write_reg(btr_pkg::CfgDrawColor,  colour);
        write_reg(btr_pkg::CfgWrapEnable, {junk[30:0],  wrap});
    endtask

    task automatic random_regs();
        program_regs($urandom_range(0, 480), $urandom_range(0, 200), $urandom_range(0, 500),
                     $urandom_range(0, 200), $urandom_range(0, 500), $urandom_range(0, 300),
                     $urandom, 1'($urandom));
    endtask

    // Random strings: mostly printable text under a first-of-string flag, with
    // newlines, unprintable bytes, stray font writes and broken strings mixed in.
    task automatic random_text(input int n);
        int made, len, pick, idx;
        logic [7:0] code;
        made = 0;
        while (made < n) begin
            len = $urandom_range(1, 24);
            for (int k = 0; k < len && made < n; k++) begin
                pick = $urandom_range(99);
                if (pick < 66) begin
                    queue_req(char_req(loaded_char(), k == 0));
                    made++;
                end else if (pick < 78) begin
                    queue_req(char_req(btr_pkg::CharNewline, k == 0));
                    made++;
                end else if (pick < 86) begin
                    code = $urandom_range(1) ? 8'($urandom_range(0, 31))
                                             : 8'($urandom_range(127, 255));
                    if (code == btr_pkg::CharNewline)
                        code = 8'h00;
                    queue_req(char_req(code, k == 0));
                    made++;
                end else if (pick < 93) begin
                    // Font rewrites count only when they land in the table
                    idx = $urandom_range(0, 127);
                    queue_req(font_req(idx, $urandom_range(0, 15), $urandom_range(0, 255)));
                    if (idx < btr_pkg::GlyphCount)
                        made++;
                end else begin
                    // Restart the string mid-way
                    code = $urandom_range(1) ? loaded_char() : 8'($urandom_range(127, 255));
                    queue_req(char_req(code, 1'b1));
                    made++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        char_bus.valid           = 1'b0;
        char_bus.req_type        = btr_pkg::ReqChar;
        char_bus.char_code       = '0;
        char_bus.first_of_string = 1'b0;
        char_bus.glyph_index     = '0;
        char_bus.glyph_row       = '0;
        char_bus.row_bits        = '0;
        row_bus.ready            = 1'b0;
        cfg_bus.valid            = 1'b0;
        cfg_bus.cfg_index        = '0;
        cfg_bus.cfg_data         = '0;

        // Shadow state as the block comes out of reset
        org_x   = '0;  org_y  = '0;  clip_l = '0;  clip_t = '0;
        clip_w  = 12'hFFF;  clip_h = 12'hFFF;
        ink     = 32'hFFFF_FFFF;  wrap_on = 1'b0;
        cur_x   = '0;  cur_y  = '0;  stopped = 1'b0;

        // Hold reset at the start, once only
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 0: reset-valued registers, font load, directed cases, no idling
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        program_regs(0, 0, 0, 0, 4095, 4095, 32'hFFFF_FFFF, 1'b0);
        // Load every row of the glyphs that the stimulus draws
        for (int k = 0; k < LoadedGlyphs; k++)
            for (int r = 0; r < btr_pkg::GlyphRows; r++)
                queue_req(font_req(int'(font_code(k)) - int'(btr_pkg::CharSpace), r,
                                   $urandom_range(0, 255)));
        queue_req(font_req(int'(btr_pkg::CharTilde - btr_pkg::CharSpace), 0, 8'hFF));
        queue_req(font_req(int'(btr_pkg::CharTilde - btr_pkg::CharSpace), 15, 8'h81));
        queue_req(font_req(0, 7, 8'h00));
        queue_req(font_req(btr_pkg::GlyphCount, 3, 8'h5A));            // first bad glyph
        queue_req(font_req(127, 15, 8'hA5));                            // last bad glyph
        queue_req(char_req(btr_pkg::CharSpace, 1'b1));
        queue_req(char_req(btr_pkg::CharTilde, 1'b0));
        queue_req(char_req(btr_pkg::CharQuestion, 1'b0));
        queue_req(char_req(8'h00, 1'b0));                               // unprintable low
        queue_req(char_req(8'h1F, 1'b0));
        queue_req(char_req(8'h7F, 1'b0));                               // just past tilde
        queue_req(char_req(8'hFF, 1'b0));
        queue_req(char_req(btr_pkg::CharNewline, 1'b0));
        queue_req(char_req(CharA, 1'b0));
        queue_req(char_req(btr_pkg::CharNewline, 1'b1));                // newline opening a string
        queue_req(char_req(btr_pkg::CharNewline, 1'b0));
        queue_req(char_req(8'h80, 1'b1));
        drain();

        // Phase 1: narrow rectangle near the screen edge with wrap on
        program_regs(300, 30, 290, 20, 120, 60, $urandom, 1'b1);
        random_text(22);
        drain();

        // Phase 2: zero-sized rectangle, everything clipped; sender mostly idle
        send_idle_pct = 85;
        program_regs(0, 0, 0, 0, 0, 0, 32'h0000_0000, 1'b1);
        random_text(12);
        drain();

        // Phase 3: every register at its top value; receiver mostly stalling
        send_idle_pct  = 0;
        recv_stall_pct = 85;
        program_regs(4095, 4095, 4095, 4095, 4095, 4095, 32'hFFFF_FFFF, 1'b1);
        queue_req(char_req(CharA, 1'b1));
        repeat (3) queue_req(char_req(loaded_char(), 1'b0));
        drain();

        // Origin right of the rectangle, so every character wraps twice and drops
        // 32 rows; walk the cursor into the saturated bottom rows until it stops
        program_regs(4095, 4088, 4000, 4095, 95, 4095, $urandom, 1'b1);
        queue_req(char_req(loaded_char(), 1'b1));
        repeat (128) queue_req(char_req(loaded_char(), 1'b0));
        repeat (2) queue_req(char_req(loaded_char(), 1'b0));    // string already stopped
        queue_req(char_req(btr_pkg::CharNewline, 1'b0));
        drain();

        // Phase 4: random registers, both sides idling now and then
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        random_regs();
        random_text(16);
        drain();

        // Phase 5: hold the receiver off while the sender keeps offering, so the
        // block fills up and stalls its input
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_regs();
        hold_req = ~hold_req;
        random_text(20);
        drain();

        // Remaining phases cycle through the pacing modes with fresh registers
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            random_regs();
            random_text(8);
            drain();
        end

        if (mismatches == 0)
            $display("** bitmap_text_renderer_clipped: PASSED **");
        else
            $display("** bitmap_text_renderer_clipped: FAILED **");
        $finish;
    end

endmodule

@@ bitmap_text_renderer_clipped.f @@
+incdir+rtl
rtl/btr_pkg.sv
rtl/btr_ifs.sv
rtl/btr_ram.sv
rtl/btr_cfg_regs.sv
rtl/btr_cursor.sv
rtl/btr_row_gen.sv
rtl/bitmap_text_renderer_clipped.sv
verif/tb.sv
